@@ hw/rtl/gb3_pkg.sv @@
// shared types, constants and helpers for the 3x3 gaussian blur stream core
package gb3_pkg;

  localparam int PIX_W    = 8;
  localparam int FW_W     = 13;
  localparam int FH_W     = 15;
  localparam int ROW_W    = 14;
  localparam int PEND_W   = 14;
  localparam int CFG_DW   = 15;
  localparam int SUM_W    = 12;
  localparam int PROD_W   = 24;
  localparam int DIM_MIN  = 3;
  localparam int DIM_RST  = 4096;
  localparam int H_MAX    = 16384;
  localparam int W_CAP    = 8191;
  localparam int DIV9_MUL = 3641;
  localparam int DIV9_SH  = 15;

  typedef enum logic {
    MODE_PIXEL = 1'b0,
    MODE_FLUSH = 1'b1
  } mode_t;

  typedef enum logic {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic left;
    logic right;
    logic top;
    logic bottom;
  } pos_flags_t;

  // flat index of a window entry, row-major, three entries a row
  function automatic logic [3:0] win_idx(input logic [1:0] row, input logic [1:0] col);
    win_idx = {1'b0, row, 1'b0} + {2'b00, row} + {2'b00, col};
  endfunction

endpackage

@@ hw/rtl/gaussian_blur_3x3_stream_core.sv @@
// 3x3 gaussian blur (1-2-1 / 2-4-2 / 1-2-1) over a raster pixel stream
// a result passes through stage 1 and the output register after the request that causes it is accepted;
//   in raster terms outputs trail inputs by one row plus one pixel
// throughput: one request per cycle when not stalled, set by the single read and write port of each line store
// reset: synchronous active-low rst_n clears counters, window and handshake state, sets frame_height
//   to 4096 and frame_width to 4096 or MAX_WIDTH if smaller; line store contents stay undefined until written
module gaussian_blur_3x3_stream_core #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input requests
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_mode,
  input  logic [gb3_pkg::PIX_W-1:0]   in_pixel,
  // result requests
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [gb3_pkg::PIX_W-1:0]   out_pixel,
  output logic                        out_last_of_frame,
  // register writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [gb3_pkg::CFG_DW-1:0]  cfg_data
);

  // column address width and a compare width that holds both columns and frame width
  localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CMPW = ((AW > gb3_pkg::FW_W) ? AW : gb3_pkg::FW_W) + 1;
  // widest usable frame width and its value after reset
  localparam logic [gb3_pkg::FW_W-1:0] W_MAX =
    gb3_pkg::FW_W'((MAX_WIDTH > gb3_pkg::W_CAP) ? gb3_pkg::W_CAP : MAX_WIDTH);
  localparam logic [gb3_pkg::FW_W-1:0] W_RST =
    (W_MAX < gb3_pkg::FW_W'(gb3_pkg::DIM_RST)) ? W_MAX : gb3_pkg::FW_W'(gb3_pkg::DIM_RST);

  // ---------------------------------------------------------------------------
  // frame geometry, kept already clamped to its legal range
  // ---------------------------------------------------------------------------
  logic [gb3_pkg::FW_W-1:0] fw_r, fw_nxt;
  logic [gb3_pkg::FH_W-1:0] fh_r, fh_nxt;
  logic                     cfg_wr;
  logic [gb3_pkg::FW_W-1:0] cfg_w;
  logic [gb3_pkg::FH_W-1:0] cfg_h;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_w     = cfg_data[gb3_pkg::FW_W-1:0];
  assign cfg_h     = cfg_data[gb3_pkg::FH_W-1:0];

  always_comb begin
    fw_nxt = fw_r;
    fh_nxt = fh_r;
    if (cfg_wr) begin
      unique case (gb3_pkg::cfg_idx_t'(cfg_index))
        gb3_pkg::CFG_FRAME_WIDTH: begin
          if (cfg_w < gb3_pkg::FW_W'(gb3_pkg::DIM_MIN)) begin
            fw_nxt = gb3_pkg::FW_W'(gb3_pkg::DIM_MIN);
          end else if (cfg_w > W_MAX) begin
            fw_nxt = W_MAX;
          end else begin
            fw_nxt = cfg_w;
          end
        end
        gb3_pkg::CFG_FRAME_HEIGHT: begin
          if (cfg_h < gb3_pkg::FH_W'(gb3_pkg::DIM_MIN)) begin
            fh_nxt = gb3_pkg::FH_W'(gb3_pkg::DIM_MIN);
          end else if (cfg_h > gb3_pkg::FH_W'(gb3_pkg::H_MAX)) begin
            fh_nxt = gb3_pkg::FH_W'(gb3_pkg::H_MAX);
          end else begin
            fh_nxt = cfg_h;
          end
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // raster position of the next input and next output, and the pending count
  // pending = how many inputs the output side trails by, 0 .. width+1
  // ---------------------------------------------------------------------------
  logic [AW-1:0]              in_col_r, in_col_nxt;
  logic [gb3_pkg::ROW_W-1:0]  in_row_r, in_row_nxt;
  logic [AW-1:0]              out_col_r, out_col_nxt;
  logic [gb3_pkg::ROW_W-1:0]  out_row_r, out_row_nxt;
  logic [gb3_pkg::PEND_W-1:0] pend_r, pend_nxt;

  logic                       acc;
  logic                       is_flush;
  logic                       pend_full;
  logic                       pend_zero;
  logic                       emit;
  logic                       active;
  logic                       in_col_wrap;
  logic                       in_row_wrap;
  logic                       out_col_wrap;
  logic                       out_row_wrap;
  logic [AW-1:0]              flush_col;
  logic [AW-1:0]              raddr;
  gb3_pkg::pos_flags_t        flags;

  assign acc       = in_valid && !in_stall;
  assign is_flush  = gb3_pkg::mode_t'(in_mode) == gb3_pkg::MODE_FLUSH;
  assign pend_zero = pend_r == '0;
  assign pend_full = pend_r == (gb3_pkg::PEND_W'(fw_r) + gb3_pkg::PEND_W'(1));
  // a pixel emits once the output trails by a full row plus one;
  // a flush emits whenever anything is still pending
  assign emit      = is_flush ? !pend_zero : pend_full;
  // a flush with nothing pending moves no counter and queues nothing into stage 1
  assign active    = !is_flush || !pend_zero;

  assign in_col_wrap  = (CMPW'(in_col_r) + CMPW'(1)) >= CMPW'(fw_r);
  assign in_row_wrap  = (gb3_pkg::FH_W'(in_row_r) + gb3_pkg::FH_W'(1)) >= fh_r;
  assign out_col_wrap = (CMPW'(out_col_r) + CMPW'(1)) >= CMPW'(fw_r);
  assign out_row_wrap = (gb3_pkg::FH_W'(out_row_r) + gb3_pkg::FH_W'(1)) >= fh_r;

  // a flush rebuilds the bottom row from the column after the output position
  assign flush_col = out_col_wrap ? '0 : out_col_r + AW'(1);
  assign raddr     = is_flush ? flush_col : in_col_r;

  // border of the output pixel about to be produced
  assign flags.left   = out_col_r == '0;
  assign flags.right  = CMPW'(out_col_r) == (CMPW'(fw_r) - CMPW'(1));
  assign flags.top    = out_row_r == '0;
  assign flags.bottom = gb3_pkg::FH_W'(out_row_r) == (fh_r - gb3_pkg::FH_W'(1));

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    pend_nxt    = pend_r;
    if (cfg_wr) begin
      // any register write restarts the stream
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      pend_nxt    = '0;
    end else if (acc) begin
      if (!is_flush) begin
        in_col_nxt = in_col_wrap ? '0 : in_col_r + AW'(1);
        if (in_col_wrap) begin
          in_row_nxt = in_row_wrap ? '0 : in_row_r + gb3_pkg::ROW_W'(1);
        end
        if (!pend_full) begin
          pend_nxt = pend_r + gb3_pkg::PEND_W'(1);
        end
      end else if (!pend_zero) begin
        pend_nxt = pend_r - gb3_pkg::PEND_W'(1);
      end
      if (emit) begin
        out_col_nxt = out_col_wrap ? '0 : out_col_r + AW'(1);
        if (out_col_wrap) begin
          out_row_nxt = out_row_wrap ? '0 : out_row_r + gb3_pkg::ROW_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r      <= W_RST;
      fh_r      <= gb3_pkg::FH_W'(gb3_pkg::DIM_RST);
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      pend_r    <= '0;
    end else begin
      fw_r      <= fw_nxt;
      fh_r      <= fh_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      pend_r    <= pend_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: request registered together with the line store read data
  // ---------------------------------------------------------------------------
  logic                      s1_v_r;
  logic                      s1_emit_r;
  logic                      s1_flush_r;
  logic [gb3_pkg::PIX_W-1:0] s1_pixel_r;
  logic [AW-1:0]             s1_col_r;
  gb3_pkg::pos_flags_t       s1_flags_r;
  logic                      b_go;

  // stage 1 retires unless its result is blocked by a held output register
  assign b_go     = s1_v_r && (!s1_emit_r || !out_valid || !out_stall);
  assign in_stall = s1_v_r && !b_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (acc) begin
      s1_v_r <= active;
    end else if (b_go) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_emit_r  <= emit;
      s1_flush_r <= is_flush;
      s1_pixel_r <= in_pixel;
      s1_col_r   <= raddr;
      s1_flags_r <= flags;
    end
  end

  // line stores: one read at acceptance, one write when stage 1 retires a pixel
  logic [gb3_pkg::PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [gb3_pkg::PIX_W-1:0] middle_mem [MAX_WIDTH];
  logic [gb3_pkg::PIX_W-1:0] up_q_r;
  logic [gb3_pkg::PIX_W-1:0] mid_q_r;
  logic                      fwd_r;
  logic [gb3_pkg::PIX_W-1:0] fwd_up_r;
  logic [gb3_pkg::PIX_W-1:0] fwd_mid_r;
  logic [gb3_pkg::PIX_W-1:0] up_eff;
  logic [gb3_pkg::PIX_W-1:0] mid_eff;
  logic                      wr_en;
  logic                      hit;

  assign wr_en   = b_go && !s1_flush_r;
  // read of the column being written in the same cycle takes the new data
  assign hit     = wr_en && (s1_col_r == raddr);
  assign up_eff  = fwd_r ? fwd_up_r : up_q_r;
  assign mid_eff = fwd_r ? fwd_mid_r : mid_q_r;

  always_ff @(posedge clk) begin
    if (acc) begin
      up_q_r    <= upper_mem[raddr];
      mid_q_r   <= middle_mem[raddr];
      fwd_r     <= hit;
      fwd_up_r  <= mid_eff;
      fwd_mid_r <= s1_pixel_r;
    end
    if (wr_en) begin
      // the middle row moves up, the new pixel becomes the middle row
      upper_mem[s1_col_r]  <= mid_eff;
      middle_mem[s1_col_r] <= s1_pixel_r;
    end
  end

  // ---------------------------------------------------------------------------
  // window shift and kernel; rows are r-1, r, r+1, column 1 is the center
  // ---------------------------------------------------------------------------
  logic [gb3_pkg::PIX_W-1:0] win_r [9];
  logic [gb3_pkg::PIX_W-1:0] nw [9];
  logic [gb3_pkg::PIX_W-1:0] col_in [3];

  // a flush repeats the middle row as the missing bottom row
  assign col_in[0] = up_eff;
  assign col_in[1] = mid_eff;
  assign col_in[2] = s1_flush_r ? mid_eff : s1_pixel_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nw[3*k]     = win_r[3*k+1];
      nw[3*k + 1] = win_r[3*k+2];
      nw[3*k + 2] = col_in[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      for (int k = 0; k < 9; k++) begin
        win_r[k] <= '0;
      end
    end else if (b_go) begin
      for (int k = 0; k < 9; k++) begin
        win_r[k] <= nw[k];
      end
    end
  end

  logic [1:0]                 lc, rc, tr, br, hc, vr;
  logic                       corner;
  logic [gb3_pkg::SUM_W-1:0]  sum_n;
  logic [gb3_pkg::SUM_W-1:0]  sum_c;
  logic [gb3_pkg::PROD_W-1:0] prod9;
  logic [gb3_pkg::PIX_W-1:0]  blur;

  // out-of-frame neighbors on a plain edge come from the edge pixel itself
  assign lc = s1_flags_r.left   ? 2'd1 : 2'd0;
  assign rc = s1_flags_r.right  ? 2'd1 : 2'd2;
  assign tr = s1_flags_r.top    ? 2'd1 : 2'd0;
  assign br = s1_flags_r.bottom ? 2'd1 : 2'd2;
  // a corner looks only inward: horizontal and vertical neighbor inside the frame
  assign hc = s1_flags_r.left ? 2'd2 : 2'd0;
  assign vr = s1_flags_r.top  ? 2'd2 : 2'd0;
  assign corner = (s1_flags_r.left || s1_flags_r.right) &&
                  (s1_flags_r.top  || s1_flags_r.bottom);

  assign sum_n =
      gb3_pkg::SUM_W'(nw[gb3_pkg::win_idx(tr, lc)])
    + (gb3_pkg::SUM_W'(nw[gb3_pkg::win_idx(tr, 2'd1)]) << 1)
    + gb3_pkg::SUM_W'(nw[gb3_pkg::win_idx(tr, rc)])
    + (gb3_pkg::SUM_W'(nw[gb3_pkg::win_idx(2'd1, lc)]) << 1)
    + (gb3_pkg::SUM_W'(nw[gb3_pkg::win_idx(2'd1, 2'd1)]) << 2)
    + (gb3_pkg::SUM_W'(nw[gb3_pkg::win_idx(2'd1, rc)]) << 1)
    + gb3_pkg::SUM_W'(nw[gb3_pkg::win_idx(br, lc)])
    + (gb3_pkg::SUM_W'(nw[gb3_pkg::win_idx(br, 2'd1)]) << 1)
    + gb3_pkg::SUM_W'(nw[gb3_pkg::win_idx(br, rc)]);

  assign sum_c =
      (gb3_pkg::SUM_W'(nw[gb3_pkg::win_idx(2'd1, 2'd1)]) << 2)
    + (gb3_pkg::SUM_W'(nw[gb3_pkg::win_idx(2'd1, hc)]) << 1)
    + (gb3_pkg::SUM_W'(nw[gb3_pkg::win_idx(vr, 2'd1)]) << 1)
    + gb3_pkg::SUM_W'(nw[gb3_pkg::win_idx(vr, hc)]);

  // floor of sum/9 by reciprocal multiply, exact for sums up to 9*255
  assign prod9 = gb3_pkg::PROD_W'(sum_c) * gb3_pkg::PROD_W'(gb3_pkg::DIV9_MUL);
  assign blur  = corner ? prod9[gb3_pkg::DIV9_SH +: gb3_pkg::PIX_W]
                        : sum_n[gb3_pkg::SUM_W-1 -: gb3_pkg::PIX_W];

  // ---------------------------------------------------------------------------
  // output register, refilled in the cycle it is taken
  // ---------------------------------------------------------------------------
  logic                      out_valid_r;
  logic [gb3_pkg::PIX_W-1:0] out_pixel_r;
  logic                      out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_go && s1_emit_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && s1_emit_r) begin
      out_pixel_r <= blur;
      out_last_r  <= s1_flags_r.right && s1_flags_r.bottom;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel         = out_pixel_r;
  assign out_last_of_frame = out_last_r;

endmodule

@@ hw/rtl/gb3_checker.sv @@
// port-level checks for the 3x3 gaussian blur stream core, bound to the top level
module gb3_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_pixel,
  input logic       out_last_of_frame
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel) && $stable(out_last_of_frame))
    else $error("result changed while stalled");

  // input back-pressure only ever comes from a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // a taken frame end is not followed straight away by another frame end
  a_last_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_frame && !out_stall |=> !(out_valid && out_last_of_frame))
    else $error("two frame ends in a row");

endmodule

bind gaussian_blur_3x3_stream_core gb3_checker u_gb3_checker (.*);
